// File: rtl/itrt_pkg.sv
// itrt_pkg: shared types, constants and helpers for the integer to radix text unit
// no dependencies
`timescale 1ns / 1ps

package itrt_pkg;

  localparam int VALUE_W       = 64;
  localparam int STEP_BITS     = 4;
  localparam int DIGIT_W       = 4;
  localparam int COUNT_W       = 7;
  localparam int RADIX_W       = 5;
  localparam int FW_W          = 6;
  localparam int CHAR_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;
  localparam int MAX_DIGITS    = 64;
  localparam int MAX_TEXT_LENGTH_DEF = 64;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR    = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_RESET       = 5'd10;
  localparam logic [FW_W-1:0]    FIELD_WIDTH_RESET = 6'd20;
  localparam logic [CHAR_W-1:0]  PAD_CHAR_RESET    = 8'd0;
  localparam logic [RADIX_W-1:0] RADIX_MIN         = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX         = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic go;
    logic load;
  } div_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < DIGIT_W'(10)) ch = CHAR_ZERO + CHAR_W'(d);
    else ch = CHAR_A + CHAR_W'(d) - CHAR_W'(10);
    return ch;
  endfunction

endpackage

// File: rtl/integer_to_radix_text_unit.sv
// integer_to_radix_text_unit: top level, control sequencer and text formatting
// depends on itrt_pkg, itrt_divider, itrt_digit_ram
`timescale 1ns / 1ps

// Usage:
//   Configuration: write radix (index 0), field_width (index 1) and pad_char
//   (index 2) on cfg_valid/cfg_index/cfg_data; cfg_ready is always high.
//   Write registers only while busy is low.
//   Input: an item is taken at a clock edge with start high and busy low.
//   Output: one character per cycle on text_char with text_valid high for
//   that cycle, leftmost first, last_char on the final one. The receiver
//   cannot stall; a value with no characters gives no strobe.
//   Sequence: the serial divider produces each digit in passes of four bits
//   each over the 64-bit magnitude, then hands it off and divides again;
//   busy drops as the last character is registered. Only one item is in
//   work at a time.
//   Reset (rst, synchronous): registers return to radix 10, field width 20,
//   no padding; the sequencer goes idle with no strobe pending.

module integer_to_radix_text_unit import itrt_pkg::*; #(
  parameter int MAX_TEXT_LENGTH = MAX_TEXT_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_W-1:0]    value,
  input  logic                  is_signed,
  output logic                  text_valid,
  output logic [CHAR_W-1:0]     text_char,
  output logic                  last_char,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_TEXT_LENGTH);

  state_t             state, state_next;
  logic [RADIX_W-1:0] radix;
  logic [FW_W-1:0]    field_width;
  logic [CHAR_W-1:0]  pad_char;

  logic               neg, neg_next;
  logic [RADIX_W-1:0] base;
  logic [CHAR_W-1:0]  pad;
  logic [COUNT_W-1:0] cap;
  logic [COUNT_W-1:0] digit_count, digit_count_next;
  logic [AW-1:0]      k, k_next;

  div_cmd_t           div_cmd;
  div_status_t        div_status;
  logic [DIGIT_W-1:0] div_digit;
  logic [VALUE_W-1:0] magnitude;
  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               emit;
  logic [CHAR_W-1:0]  emit_char;

  logic [RADIX_W-1:0] base_sat;
  logic [COUNT_W-1:0] cap_calc;
  logic [COUNT_W-1:0] textlen;
  logic [COUNT_W-1:0] len;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      field_width <= FIELD_WIDTH_RESET;
      pad_char    <= PAD_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIX:       radix       <= cfg_data[RADIX_W-1:0];
        REG_FIELD_WIDTH: field_width <= cfg_data[FW_W-1:0];
        REG_PAD_CHAR:    pad_char    <= cfg_data;
        default: ;
      endcase
    end
  end

  // item setup values, taken at start
  assign neg_next  = is_signed && value[VALUE_W-1];
  assign magnitude = neg_next ? (VALUE_W'(0) - value) : value;

  always_comb begin
    logic [COUNT_W-1:0] c;
    if (radix < RADIX_MIN) base_sat = RADIX_MIN;
    else if (radix > RADIX_MAX) base_sat = RADIX_MAX;
    else base_sat = radix;
    c = COUNT_W'(field_width);
    if (c > COUNT_W'(MAX_TEXT_LENGTH - 1)) c = COUNT_W'(MAX_TEXT_LENGTH - 1);
    if (neg_next) begin
      c = c + COUNT_W'(1);
      if (c > COUNT_W'(MAX_TEXT_LENGTH - 1)) c = COUNT_W'(MAX_TEXT_LENGTH - 1);
    end
    cap_calc = c;
  end

  assign textlen = digit_count + COUNT_W'(neg);
  assign len     = ((pad != CHAR_NUL) || (textlen > cap)) ? cap : textlen;

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      neg  <= neg_next;
      base <= base_sat;
      cap  <= cap_calc;
      pad  <= (neg_next && pad_char == CHAR_ZERO) ? CHAR_SPACE : pad_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      digit_count <= '0;
    end else begin
      state       <= state_next;
      digit_count <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
  end

  always_comb begin
    state_next       = state;
    digit_count_next = digit_count;
    k_next           = k;
    div_cmd          = '0;
    ram_we           = 1'b0;
    emit             = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          div_cmd.go       = 1'b1;
          div_cmd.load     = 1'b1;
          digit_count_next = '0;
          state_next       = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          ram_we           = (digit_count < COUNT_W'(MAX_TEXT_LENGTH));
          digit_count_next = digit_count + COUNT_W'(1);
          if (div_status.zero || digit_count_next == COUNT_W'(MAX_DIGITS)) begin
            state_next = ST_SETUP;
          end else begin
            div_cmd.go = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        if (len == '0) begin
          state_next = ST_IDLE;
        end else begin
          k_next     = AW'(len - COUNT_W'(1));
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (k == '0) state_next = ST_IDLE;
        else k_next = k - AW'(1);
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // character at position k from the right
  always_comb begin
    if (COUNT_W'(k) < digit_count) emit_char = digit_ascii(ram_rdata);
    else if (neg && COUNT_W'(k) == digit_count) emit_char = CHAR_MINUS;
    else emit_char = pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      text_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      text_char <= emit_char;
      last_char <= (k == '0);
    end
  end

  itrt_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .cmd       (div_cmd),
    .magnitude (magnitude),
    .base      (state == ST_IDLE ? base_sat : base),
    .status    (div_status),
    .digit     (div_digit)
  );

  itrt_digit_ram #(
    .DEPTH (MAX_TEXT_LENGTH)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[AW-1:0]),
    .wdata (div_digit),
    .raddr (k_next),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (text_valid && last_char) |=> !text_valid)
    else $error("character strobe after last character");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_W'(MAX_DIGITS))
    else $error("digit count out of range");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> COUNT_W'(k) < cap)
    else $error("emit position beyond text window");
`endif

endmodule

// File: rtl/itrt_divider.sv
// itrt_divider: serial restoring divider, four quotient bits per cycle
// depends on itrt_pkg
`timescale 1ns / 1ps

module itrt_divider import itrt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  div_cmd_t             cmd,
  input  logic [VALUE_W-1:0]   magnitude,
  input  logic [RADIX_W-1:0]   base,
  output div_status_t          status,
  output logic [DIGIT_W-1:0]   digit
);

  localparam int PASSES = VALUE_W / STEP_BITS;
  localparam int CNT_W  = $clog2(PASSES);

  logic [VALUE_W-1:0]   quot;
  logic [DIGIT_W-1:0]   rem;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  logic                 done;
  logic [DIGIT_W-1:0]   rem_next;
  logic [STEP_BITS-1:0] qbits;

  // dividend bits leave at the top, quotient bits enter at the bottom
  always_comb begin
    logic [DIGIT_W:0] t;
    rem_next = rem;
    qbits    = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      t = {rem_next, quot[VALUE_W-1-j]};
      if (t >= base) begin
        rem_next = DIGIT_W'(t - base);
        qbits[STEP_BITS-1-j] = 1'b1;
      end else begin
        rem_next = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PASSES - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rem <= '0;
      if (cmd.load) quot <= magnitude;
    end else if (run) begin
      rem  <= rem_next;
      quot <= {quot[VALUE_W-STEP_BITS-1:0], qbits};
    end
  end

  assign status.done = done;
  assign status.zero = (quot == '0);
  assign digit       = rem;

endmodule

// File: rtl/itrt_digit_ram.sv
// itrt_digit_ram: digit store, one write port and one registered read port
// depends on itrt_pkg
`timescale 1ns / 1ps

module itrt_digit_ram import itrt_pkg::*; #(
  parameter int DEPTH = MAX_TEXT_LENGTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DIGIT_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DIGIT_W-1:0]       rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: tb/integer_to_radix_text_unit_tb.sv
// integer_to_radix_text_unit_tb: self-checking bench for the integer to radix text unit
// predicts the character stream of every value and checks each strobe in order
// depends on itrt_pkg and integer_to_radix_text_unit
`timescale 1ns / 1ps

module integer_to_radix_text_unit_tb;
  import itrt_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 17 * MAX_DIGITS + 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [CHAR_W-1:0] glyph;
    logic              is_last;
  } text_entry_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [VALUE_W-1:0]    value;
  logic                  is_signed;
  logic                  text_valid;
  logic [CHAR_W-1:0]     text_char;
  logic                  last_char;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow copy of the register file
  logic [RADIX_W-1:0] cur_radix;
  logic [FW_W-1:0]    cur_width;
  logic [CHAR_W-1:0]  cur_pad;

  text_entry_t pending_text[$];
  int mismatch_count;
  int chars_checked;
  int values_sent;
  int settings_used;
  int cycle_count;
  bit no_gaps;

  integer_to_radix_text_unit uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .is_signed  (is_signed),
    .text_valid (text_valid),
    .text_char  (text_char),
    .last_char  (last_char),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // expected text of one value under the current register settings
  function automatic void predict_text(input logic [VALUE_W-1:0] v, input logic sgn);
    logic [8*16-1:0]    glyphs;
    logic [DIGIT_W-1:0] digit_buf [MAX_DIGITS];
    logic [VALUE_W-1:0] mag;
    logic [RADIX_W-1:0] base;
    logic [CHAR_W-1:0]  pad;
    logic [CHAR_W-1:0]  ch;
    logic               neg;
    int                 ndig;
    int                 window;
    int                 textlen;
    int                 len;
    int                 k;
    text_entry_t        entry;
    glyphs = "0123456789abcdef";
    neg = sgn && v[VALUE_W-1];
    mag = neg ? (~v + 64'd1) : v;
    base = cur_radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    pad = cur_pad;
    ndig = 0;
    do begin
      digit_buf[ndig] = DIGIT_W'(mag % VALUE_W'(base));
      mag = mag / VALUE_W'(base);
      ndig++;
    end while (mag != 0 && ndig < MAX_DIGITS);
    window = (int'(cur_width) > MAX_TEXT_LENGTH_DEF - 1) ? MAX_TEXT_LENGTH_DEF - 1
                                                          : int'(cur_width);
    if (neg) begin
      window = window + 1;
      if (window > MAX_TEXT_LENGTH_DEF - 1) window = MAX_TEXT_LENGTH_DEF - 1;
      if (pad == CHAR_ZERO) pad = CHAR_SPACE;
    end
    textlen = ndig + (neg ? 1 : 0);
    len = (pad != CHAR_NUL || textlen > window) ? window : textlen;
    for (int i = 0; i < len; i++) begin
      k = len - 1 - i;
      if (k < ndig) ch = glyphs[8*(15 - int'(digit_buf[k])) +: 8];
      else if (neg && k == ndig) ch = CHAR_MINUS;
      else ch = pad;
      entry.glyph = ch;
      entry.is_last = (i == len - 1);
      pending_text.push_back(entry);
    end
  endfunction

  // start stays high across back-to-back items; a drawn gap holds it low
  // until after the unit goes idle
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic sgn);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap - 1) @(posedge clk);
    end
    start     <= 1'b1;
    value     <= v;
    is_signed <= sgn;
    do @(posedge clk); while (busy);
    predict_text(v, sgn);
    values_sent++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input logic [RADIX_W-1:0] r, input logic [FW_W-1:0] w,
                               input logic [CHAR_W-1:0] p);
    cfg_valid <= 1'b1;
    put_reg(REG_RADIX, CFG_DATA_W'(r));
    put_reg(REG_FIELD_WIDTH, CFG_DATA_W'(w));
    put_reg(REG_PAD_CHAR, p);
    cfg_valid <= 1'b0;
    cur_radix = r;
    cur_width = w;
    cur_pad   = p;
    settings_used++;
  endtask

  // let all text drain; a zero-width value may still be dividing with nothing expected
  task automatic quiesce();
    start <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk);
    if (cur_width == 0) repeat (DRAIN_CYCLES) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = {$urandom, $urandom};
      1: v = VALUE_W'($urandom_range(0, 1000));
      2: v = 64'd0 - VALUE_W'($urandom_range(1, 1000));
      3: v = (64'd1 << $urandom_range(0, 63)) - VALUE_W'($urandom_range(0, 1));
      4: begin
        case ($urandom_range(0, 3))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7fff_ffff_ffff_ffff;
          2: v = '1;
          default: v = '0;
        endcase
      end
      5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = {32'hffff_ffff, $urandom};
    endcase
    return v;
  endfunction

  // result checker: strobes cannot be stalled, so every one is taken as it comes
  always @(posedge clk) begin
    text_entry_t want;
    if (!rst && text_valid) begin
      chars_checked++;
      if (pending_text.size() == 0) begin
        flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", text_char, last_char));
      end else begin
        want = pending_text.pop_front();
        if (text_char !== want.glyph || last_char !== want.is_last) begin
          flag_mismatch($sformatf("char exp 0x%02h last=%0b, got 0x%02h last=%0b",
                                  want.glyph, want.is_last, text_char, last_char));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d chars still expected",
             cycle_count, pending_text.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_reset_defaults();
    send_value(64'd0, 1'b0);
    send_value('1, 1'b0);
    send_value(64'h8000_0000_0000_0000, 1'b1);
    send_value('1, 1'b1);
    send_value(64'd1234567890, 1'b1);
    send_value(64'h7fff_ffff_ffff_ffff, 1'b1);
    quiesce();
  endtask

  task automatic test_radix_extremes();
    load_settings(5'd16, 6'd63, "*");
    send_value(64'd0, 1'b0);
    send_value(64'h0123_4567_89ab_cdef, 1'b0);
    send_value(64'hfedc_ba98_7654_3210, 1'b1);
    quiesce();
    // 64 binary digits overflow the 63 character window
    load_settings(5'd2, 6'd63, CHAR_NUL);
    send_value('1, 1'b0);
    send_value(64'h8000_0000_0000_0000, 1'b1);
    send_value(64'd1, 1'b0);
    quiesce();
  endtask

  task automatic test_zero_width();
    load_settings(5'd10, 6'd0, CHAR_NUL);
    send_value(64'd5, 1'b0);
    send_value(64'hffff_ffff_ffff_fffd, 1'b1);
    send_value(64'd0, 1'b0);
    quiesce();
    load_settings(5'd7, 6'd0, "x");
    send_value(64'hffff_ffff_ffff_fff0, 1'b1);
    quiesce();
  endtask

  task automatic test_pad_rules();
    load_settings(5'd10, 6'd8, CHAR_ZERO);
    send_value(64'd42, 1'b0);
    send_value(64'd0 - 64'd42, 1'b1);
    quiesce();
    load_settings(5'd16, 6'd4, 8'hff);
    send_value(64'h12345, 1'b0);
    send_value('1, 1'b1);
    quiesce();
  endtask

  task automatic test_radix_saturation();
    load_settings(5'd0, 6'd12, ".");
    send_value(64'd5, 1'b0);
    quiesce();
    load_settings(5'd1, 6'd12, ".");
    send_value(64'd5, 1'b0);
    quiesce();
    load_settings(5'd17, 6'd12, CHAR_NUL);
    send_value(64'd255, 1'b0);
    quiesce();
    load_settings(5'd31, 6'd12, CHAR_NUL);
    send_value(64'd0 - 64'd255, 1'b1);
    quiesce();
  endtask

  task automatic test_random_values();
    logic [RADIX_W-1:0] r;
    logic [FW_W-1:0]    w;
    logic [CHAR_W-1:0]  p;
    for (int phase = 0; phase < 10; phase++) begin
      r = ($urandom_range(0, 4) == 0) ? RADIX_W'($urandom_range(0, 31))
                                      : RADIX_W'($urandom_range(2, 16));
      case ($urandom_range(0, 4))
        0: w = '0;
        1: w = '1;
        default: w = FW_W'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 4))
        0, 1: p = CHAR_NUL;
        2: p = CHAR_ZERO;
        default: p = CHAR_W'($urandom);
      endcase
      load_settings(r, w, p);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 24; n++) begin
        send_value(random_value(), 1'($urandom_range(0, 1)));
      end
      no_gaps = 1'b0;
      quiesce();
    end
  endtask

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    value          = '0;
    is_signed      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_RADIX;
    cfg_data       = '0;
    cur_radix      = RADIX_RESET;
    cur_width      = FIELD_WIDTH_RESET;
    cur_pad        = PAD_CHAR_RESET;
    mismatch_count = 0;
    chars_checked  = 0;
    values_sent    = 0;
    settings_used  = 1;
    no_gaps        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_radix_extremes();
    test_zero_width();
    test_pad_rules();
    test_radix_saturation();
    test_random_values();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("converted %0d values under %0d register settings, %0d characters checked",
             values_sent, settings_used, chars_checked);
    $display("%0d mismatches, %0d characters never arrived",
             mismatch_count, pending_text.size());
    if (mismatch_count == 0 && pending_text.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
